/* hw/rtl/chte_pkg.sv */
package chte_pkg;

  localparam int NumBucketsDef  = 8;
  localparam int BucketDepthDef = 16;

  localparam logic [31:0] HashSeed = 32'd5381;
  localparam logic [31:0] HashMul  = 32'd11;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_UPDATED = 3'd1,
    ST_FOUND   = 3'd2,
    ST_MISSING = 3'd3,
    ST_REMOVED = 3'd4,
    ST_FULL    = 3'd5,
    ST_CLEARED = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_value;
    logic [7:0]  entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_BUCKET,
    S_RD,
    S_CMP,
    S_RDLAST,
    S_MOVE,
    S_DONE,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic hash_step;  // fold one key byte
    logic red_start;  // start bucket reduction of the scaled hash
    logic red_step;   // reduce one nibble
    logic set_bucket; // take reduced bucket
    logic rd_slot;    // read slot at scan index
    logic rd_last;    // read last slot of bucket
    logic next_idx;
    logic wr_update;  // write value at hit index
    logic wr_append;  // append key/value, bump fill
    logic wr_move;    // move last into hit slot, drop fill
    logic clear_all;
    logic set_rsp;
    logic [2:0] status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       hash_done;
    logic       red_done;
    logic       scan_end;  // index reached fill
    logic       hit;       // key read equals request key
    logic       full;
  } sts_t;

endpackage

/* hw/rtl/chte_ctrl.sv */
module chte_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  chte_pkg::sts_t  sts,
  output chte_pkg::cmd_t  cmd
);
  import chte_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.kind == KIND_CLEAR) begin
          cmd.clear_all = 1'b1;
          cmd.status = ST_CLEARED;
          state_nxt = S_DONE;
        end else if (sts.hash_done) begin
          cmd.red_start = 1'b1;
          state_nxt = S_BUCKET;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_BUCKET: begin
        if (sts.red_done) begin
          cmd.set_bucket = 1'b1;
          state_nxt = S_RD;
        end else begin
          cmd.red_step = 1'b1;
        end
      end
      S_RD: begin
        if (sts.scan_end) begin
          state_nxt = S_DONE;
          cmd.status = ST_MISSING;
          if (sts.kind == KIND_INSERT) begin
            if (sts.full) begin
              cmd.status = ST_FULL;
            end else begin
              cmd.wr_append = 1'b1;
              cmd.status = ST_ADDED;
            end
          end
        end else begin
          cmd.rd_slot = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          case (sts.kind)
            KIND_INSERT: begin
              cmd.wr_update = 1'b1;
              cmd.status = ST_UPDATED;
              state_nxt = S_DONE;
            end
            KIND_FIND: begin
              cmd.status = ST_FOUND;
              state_nxt = S_DONE;
            end
            default: begin
              cmd.rd_last = 1'b1;
              state_nxt = S_RDLAST;
            end
          endcase
        end else begin
          cmd.next_idx = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RDLAST: state_nxt = S_MOVE;
      S_MOVE: begin
        cmd.wr_move = 1'b1;
        cmd.status = ST_REMOVED;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.set_rsp = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/chte_dp.sv */
module chte_dp #(
  parameter int NUM_BUCKETS  = chte_pkg::NumBucketsDef,
  parameter int BUCKET_DEPTH = chte_pkg::BucketDepthDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  chte_pkg::req_t  req,
  input  chte_pkg::cmd_t  cmd,
  output chte_pkg::sts_t  sts,
  output chte_pkg::rsp_t  rsp
);
  import chte_pkg::*;

  localparam int Slots = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int IW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FW = $clog2(BUCKET_DEPTH + 1);
  localparam int AW = $clog2(Slots);
  localparam int TW = $clog2(Slots + 1);
  localparam int RW = BW + 4;
  localparam logic [FW-1:0] DepthC = FW'(BUCKET_DEPTH);
  localparam logic [RW-1:0] Sub8 = RW'(NUM_BUCKETS * 8);
  localparam logic [RW-1:0] Sub4 = RW'(NUM_BUCKETS * 4);
  localparam logic [RW-1:0] Sub2 = RW'(NUM_BUCKETS * 2);
  localparam logic [RW-1:0] Sub1 = RW'(NUM_BUCKETS);

  logic [63:0] slot_keys [Slots];
  logic [63:0] slot_values [Slots];

  logic [1:0]    kind_r;
  logic [63:0]   key_r, value_r;
  logic [31:0]   hash_r;
  logic [3:0]    byte_r;
  logic [31:0]   red_val_r;
  logic [BW-1:0] red_acc_r;
  logic [3:0]    red_cnt_r;
  logic [BW-1:0] bucket_r;
  logic [FW-1:0] idx_r;
  logic [FW-1:0] fill_r [NUM_BUCKETS];
  logic [TW-1:0] total_r;
  logic [63:0]   rd_key_r, rd_val_r;
  rsp_t          rsp_r;
  logic [31:0]   hprod;
  logic [RW-1:0] red_t0, red_t1, red_t2, red_t3, red_t4;
  logic [FW-1:0] fill_cur;
  logic [AW-1:0] base, a_idx, a_last, a_fill;

  assign hprod    = hash_r * HashMul;
  assign fill_cur = fill_r[bucket_r];
  assign base     = AW'(bucket_r) * AW'(BUCKET_DEPTH);
  assign a_idx    = base + AW'(idx_r[IW-1:0]);
  assign a_last   = base + AW'(fill_cur - FW'(1));
  assign a_fill   = base + AW'(fill_cur);

  // remainder by the bucket count, top nibble first: acc = (acc*16 + nib) mod N
  always_comb begin
    red_t0 = {red_acc_r, red_val_r[31:28]};
    red_t1 = (red_t0 >= Sub8) ? red_t0 - Sub8 : red_t0;
    red_t2 = (red_t1 >= Sub4) ? red_t1 - Sub4 : red_t1;
    red_t3 = (red_t2 >= Sub2) ? red_t2 - Sub2 : red_t2;
    red_t4 = (red_t3 >= Sub1) ? red_t3 - Sub1 : red_t3;
  end

  assign sts.kind      = kind_r;
  assign sts.hash_done = byte_r[3];
  assign sts.red_done  = red_cnt_r[3];
  assign sts.scan_end  = (idx_r >= fill_cur);
  assign sts.hit       = (rd_key_r == key_r);
  assign sts.full      = (fill_cur >= DepthC);
  assign rsp = rsp_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= req.kind;
      key_r   <= req.key;
      value_r <= req.value;
      hash_r  <= HashSeed;
      byte_r  <= '0;
      idx_r   <= '0;
    end
    if (cmd.hash_step) begin
      hash_r  <= (hash_r << 5) + hash_r + 32'(key_r[7:0]);
      key_r   <= {key_r[7:0], key_r[63:8]};
      byte_r  <= byte_r + 4'd1;
    end
    if (cmd.red_start) begin
      red_val_r <= hprod;
      red_acc_r <= '0;
      red_cnt_r <= '0;
    end
    if (cmd.red_step) begin
      red_val_r <= red_val_r << 4;
      red_acc_r <= red_t4[BW-1:0];
      red_cnt_r <= red_cnt_r + 4'd1;
    end
    if (cmd.set_bucket) bucket_r <= red_acc_r;
    if (cmd.next_idx) idx_r <= idx_r + FW'(1);
    if (cmd.rd_slot) begin
      rd_key_r <= slot_keys[a_idx];
      rd_val_r <= slot_values[a_idx];
    end
    if (cmd.rd_last) begin
      rd_key_r  <= slot_keys[a_last];
      rd_val_r  <= slot_values[a_last];
    end
    if (cmd.wr_update) slot_values[a_idx] <= value_r;
    if (cmd.wr_append) begin
      slot_keys[a_fill]   <= key_r;
      slot_values[a_fill] <= value_r;
    end
    if (cmd.wr_move) begin
      slot_keys[a_idx]   <= rd_key_r;
      slot_values[a_idx] <= rd_val_r;
    end
    if (cmd.set_rsp) begin
      rsp_r.status      <= cmd.status;
      rsp_r.found_value <= (cmd.status == ST_FOUND) ? rd_val_r : 64'd0;
      rsp_r.entry_count <= 8'(total_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int b = 0; b < NUM_BUCKETS; b++) fill_r[b] <= '0;
    end else if (cmd.clear_all) begin
      total_r <= '0;
      for (int b = 0; b < NUM_BUCKETS; b++) fill_r[b] <= '0;
    end else if (cmd.wr_append) begin
      total_r <= total_r + TW'(1);
      fill_r[bucket_r] <= fill_cur + FW'(1);
    end else if (cmd.wr_move) begin
      if (total_r != '0) total_r <= total_r - TW'(1);
      fill_r[bucket_r] <= fill_cur - FW'(1);
    end
  end

endmodule

/* hw/rtl/chte_resp.sv */
module chte_resp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      status_in,
  input  logic            set,
  output logic [2:0]      status_out
);
  import chte_pkg::*;

  logic [2:0] st_r;

  // holds the outcome from the decision cycle until the result is built
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_ADDED;
    end else if (set) begin
      st_r <= status_in;
    end
  end

  assign status_out = st_r;

endmodule

/* hw/rtl/chained_hash_table_engine.sv */
// chained hash table engine: 64-bit key/value store in NUM_BUCKETS buckets
// of BUCKET_DEPTH slots, bucket picked by a djb2 hash times 11
// input channel: in_valid/in_stall with in_data (kind, key, value)
// kind: insert or update, find, remove, clear all
// output channel: out_valid/out_stall with out_data (status, value, count)
// one request at a time; in_stall is high from accept until the result
// transfer completes
// a request steps through accept, byte-wise hash, nibble-wise bucket reduction,
// a serial scan of the bucket's filled slots, finish and result; clear skips
// hash, reduction and scan
// the slot scan is serial over key and value memories shared by all buckets
// reset empties every bucket and zeroes the entry count; slot memories
// hold no reset value and are only read below a bucket's fill
// while out_stall is high the result holds and no request is taken
module chained_hash_table_engine #(
  parameter int NUM_BUCKETS  = chte_pkg::NumBucketsDef,
  parameter int BUCKET_DEPTH = chte_pkg::BucketDepthDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  chte_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output chte_pkg::rsp_t out_data
);
  import chte_pkg::*;

  cmd_t cmd, cmd_dp;
  sts_t sts;
  rsp_t rsp;
  logic [2:0] st_hold;

  chte_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd
  );

  chte_resp u_resp (
    .clk, .rst_n, .status_in(cmd.status),
    .set(cmd.status != ST_ADDED || cmd.wr_append), .status_out(st_hold)
  );

  always_comb begin
    cmd_dp = cmd;
    cmd_dp.status = st_hold;
  end

  chte_dp #(.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_dp (
    .clk, .rst_n, .req(in_data), .cmd(cmd_dp), .sts, .rsp
  );

  assign out_data = rsp;

endmodule
